/* design/slw_pkg.sv */
// Shared types and constants for the sleep list tick waker.
// No dependencies; used by slw_entry_unit and sleep_list_tick_waker_top.
package slw_pkg;

  // Operation codes carried in the low bits of the input item
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Result status codes
  localparam logic STATUS_WOKEN  = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Fixed field widths
  localparam int ID_W       = 4;
  localparam int IN_TICKS_W = 32;

  // Per-entry verdict from the shared entry unit
  typedef struct packed {
    logic hit;      // entry thread matches the item's thread
    logic expired;  // decremented count reached zero
    logic drop;     // entry leaves the table under the current operation
  } unit_flags_t;

endpackage

/* design/slw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slw_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/slw_entry_unit.sv */
// Shared entry unit: decrements one stored count, compares the thread id,
// and decides whether the entry leaves the table. Depends on slw_pkg.
module slw_entry_unit #(
  parameter int TICK_WIDTH = 32
) (
  input  logic [1:0]                 op,
  input  logic [slw_pkg::ID_W-1:0]   target_id,
  input  logic [slw_pkg::ID_W-1:0]   ent_thread,
  input  logic [TICK_WIDTH-1:0]      ent_ticks,
  output logic [TICK_WIDTH-1:0]      new_ticks,
  output slw_pkg::unit_flags_t       flags
);

  // decrement wraps like the count register would
  assign new_ticks = ent_ticks - TICK_WIDTH'(1);

  always_comb begin
    flags.hit     = (ent_thread == target_id);
    flags.expired = (new_ticks == '0);
    case (op)
      slw_pkg::OP_TICK:   flags.drop = flags.expired;
      slw_pkg::OP_REMOVE: flags.drop = flags.hit;
      default:            flags.drop = 1'b0;
    endcase
  end

endmodule

/* design/sleep_list_tick_waker_top.sv */
// Top level of the sleep list tick waker: sequencer, table RAM, result stage.
// Depends on slw_pkg, slw_ram and slw_entry_unit.
//
//  Channel | Dir | Signals                      | Contents
//  s_      | in  | tvalid tready tdata[39:0]    | operation, thread_id, sleep_ticks
//  m_      | out | tvalid tready tdata[7:0]     | woken_thread
//          |     | tuser tlast                  | status, last of the item's results
//
// One item at a time: s_tready is high only while the sequencer is idle.
// A remove or tick with n stored entries runs from accept to the next accept
// as: accept, per entry a RAM read, then evaluate and compact in the shared
// entry unit, then finish. Empty table or code 3: the accept alone.
// An insert reads and evaluates each entry until the thread is found, else all
// of them and then appends (with a finish step on a reject).
// One result is held back so the final one can carry tlast; a stalled m_ side
// stops the walk when a new result arrives while two are pending, and holds
// the finish until the output register is free.
// Reset (rst, synchronous) empties the table at once; no clearing pass.
module sleep_list_tick_waker_top #(
  parameter int MAX_SLEEPERS = 16,
  parameter int TICK_WIDTH   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [1:0] operation, [5:2] thread_id, [37:6] sleep_ticks
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [3:0] woken_thread
  output logic        m_tuser,   // [0] status
  output logic        m_tlast
);

  localparam int IDX_W   = (MAX_SLEEPERS > 1) ? $clog2(MAX_SLEEPERS) : 1;
  localparam int CNT_W   = $clog2(MAX_SLEEPERS + 1);
  localparam int ID_W    = slw_pkg::ID_W;
  localparam int ENT_W   = TICK_WIDTH + ID_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SLEEPERS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_EV   = 3'd2;
  localparam logic [2:0] ST_INSW = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // input fields
  logic [1:0]                       in_op;
  logic [ID_W-1:0]                  in_id;
  logic [slw_pkg::IN_TICKS_W-1:0]   in_ticks;
  logic [TICK_WIDTH-1:0]            len_sat;

  assign in_op    = s_tdata[1:0];
  assign in_id    = s_tdata[5:2];
  assign in_ticks = s_tdata[37:6];

  // saturate to the count width, zero taken as one
  logic [TICK_WIDTH-1:0] len_clip;
  generate
    if (TICK_WIDTH >= slw_pkg::IN_TICKS_W) begin : g_wide
      assign len_clip = TICK_WIDTH'(in_ticks);
    end else begin : g_narrow
      assign len_clip = (|in_ticks[slw_pkg::IN_TICKS_W-1:TICK_WIDTH]) ? '1
                                                                      : in_ticks[TICK_WIDTH-1:0];
    end
  endgenerate
  assign len_sat = (len_clip == '0) ? TICK_WIDTH'(1) : len_clip;

  // registers
  logic [2:0]            state, state_next;
  logic [1:0]            op_q, op_q_next;
  logic [ID_W-1:0]       id_q, id_q_next;
  logic [TICK_WIDTH-1:0] len_q, len_q_next;
  logic [CNT_W-1:0]      r, r_next;
  logic [CNT_W-1:0]      w, w_next;
  logic [CNT_W-1:0]      count, count_next;
  logic                  pend_valid, pend_valid_next;
  logic [ID_W-1:0]       pend_id, pend_id_next;
  logic                  pend_status, pend_status_next;
  logic                  out_valid, out_valid_next;
  logic [ID_W-1:0]       out_id, out_id_next;
  logic                  out_status, out_status_next;
  logic                  out_last, out_last_next;

  // table RAM and shared unit
  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [ENT_W-1:0]      ram_wdata, ram_rdata;
  logic [ID_W-1:0]       ent_thread;
  logic [TICK_WIDTH-1:0] ent_ticks, new_ticks;
  slw_pkg::unit_flags_t  flags;

  slw_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SLEEPERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent_thread = ram_rdata[ID_W-1:0];
  assign ent_ticks  = ram_rdata[ENT_W-1:ID_W];

  slw_entry_unit #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_unit (
    .op         (op_q),
    .target_id  (id_q),
    .ent_thread (ent_thread),
    .ent_ticks  (ent_ticks),
    .new_ticks  (new_ticks),
    .flags      (flags)
  );

  // ports
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {(8 - ID_W)'(0), out_id};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  // sequencer
  always_comb begin
    logic             out_free;
    logic             stall;
    logic [CNT_W-1:0] r_inc;
    logic [CNT_W-1:0] w_upd;

    out_free = !out_valid || m_tready;
    stall    = flags.drop && pend_valid && !out_free;
    r_inc    = r + CNT_W'(1);
    w_upd    = w;

    state_next       = state;
    op_q_next        = op_q;
    id_q_next        = id_q;
    len_q_next       = len_q;
    r_next           = r;
    w_next           = w;
    count_next       = count;
    pend_valid_next  = pend_valid;
    pend_id_next     = pend_id;
    pend_status_next = pend_status;
    out_valid_next   = out_valid && !m_tready;
    out_id_next      = out_id;
    out_status_next  = out_status;
    out_last_next    = out_last;

    ram_we    = 1'b0;
    ram_waddr = w[IDX_W-1:0];
    ram_wdata = {new_ticks, ent_thread};
    ram_re    = 1'b0;
    ram_raddr = r[IDX_W-1:0];

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          op_q_next  = in_op;
          id_q_next  = in_id;
          len_q_next = len_sat;
          r_next     = '0;
          w_next     = '0;
          if (in_op == slw_pkg::OP_NONE) begin
            state_next = ST_IDLE;
          end else if (count == '0) begin
            state_next = (in_op == slw_pkg::OP_INSERT) ? ST_INSW : ST_IDLE;
          end else begin
            state_next = ST_RD;
          end
        end
      end

      ST_RD: begin
        ram_re     = 1'b1;
        state_next = ST_EV;
      end

      ST_EV: begin
        if (!stall) begin
          if (op_q == slw_pkg::OP_INSERT && flags.hit) begin
            // thread already asleep: reload in place
            ram_we     = 1'b1;
            ram_waddr  = r[IDX_W-1:0];
            ram_wdata  = {len_q, ent_thread};
            state_next = ST_IDLE;
          end else begin
            if (flags.drop) begin
              // hold the newest result, release the older one
              if (pend_valid) begin
                out_valid_next  = 1'b1;
                out_id_next     = pend_id;
                out_status_next = pend_status;
                out_last_next   = 1'b0;
              end
              pend_valid_next  = 1'b1;
              pend_id_next     = ent_thread;
              pend_status_next = slw_pkg::STATUS_WOKEN;
            end else if (op_q != slw_pkg::OP_INSERT) begin
              // compact the surviving entry down to the write pointer
              ram_we = 1'b1;
              if (op_q == slw_pkg::OP_REMOVE) begin
                // early remove leaves the other counts as they are
                ram_wdata = ram_rdata;
              end
              w_upd  = w + CNT_W'(1);
            end
            w_next = w_upd;
            r_next = r_inc;
            if (r_inc == count) begin
              if (op_q == slw_pkg::OP_INSERT) begin
                state_next = ST_INSW;
              end else begin
                count_next = w_upd;
                state_next = ST_FIN;
              end
            end else begin
              state_next = ST_RD;
            end
          end
        end
      end

      ST_INSW: begin
        if (count < CNT_MAX) begin
          ram_we     = 1'b1;
          ram_waddr  = count[IDX_W-1:0];
          ram_wdata  = {len_q, id_q};
          count_next = count + CNT_W'(1);
          state_next = ST_IDLE;
        end else begin
          pend_valid_next  = 1'b1;
          pend_id_next     = id_q;
          pend_status_next = slw_pkg::STATUS_REJECT;
          state_next       = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          out_id_next     = pend_id;
          out_status_next = pend_status;
          out_last_next   = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_q        <= op_q_next;
    id_q        <= id_q_next;
    len_q       <= len_q_next;
    r           <= r_next;
    w           <= w_next;
    pend_id     <= pend_id_next;
    pend_status <= pend_status_next;
    out_id      <= out_id_next;
    out_status  <= out_status_next;
    out_last    <= out_last_next;
  end

  // table never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("entry count above table depth");

  // compaction pointer never passes the read pointer
  a_w_behind_r: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EV) |-> (w <= r))
    else $error("write pointer ahead of read pointer");

  // every held result is flushed before the next item
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("result left pending at idle");

  // tick on an empty table finishes at once
  a_empty_tick: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && in_op == slw_pkg::OP_TICK && count == '0)
      |=> (state == ST_IDLE))
    else $error("empty tick did not return to idle");

endmodule
